// File: design/bcd_pkg.sv
// Package for the block cache directory: sizes, opcodes and request/result types.
// No dependencies.
`timescale 1ns / 1ps
package bcd_pkg;
  localparam int ENTRIES   = 16;
  localparam int AGE_LIMIT = 255;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int AGE_W     = $clog2(AGE_LIMIT + 1);

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  typedef struct packed {
    logic [15:0] device;
    logic [47:0] offset;
    logic [31:0] block;
    logic [16:0] size;
  } tag_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] device_id;
    logic [47:0] base_offset;
    logic [31:0] block_number;
    logic [16:0] block_size;
    logic        allocate_on_miss;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [5:0]  entry_index;
    logic        allocated;
    logic        writeback_valid;
    logic [15:0] wb_device;
    logic [47:0] wb_offset;
    logic [31:0] wb_block;
    logic [16:0] wb_size;
    logic        last;
  } rsp_t;
endpackage

// File: design/bcd_tag_ram.sv
// Tag store of the block cache directory: one write port, one registered read port.
// Depends on bcd_pkg.
`timescale 1ns / 1ps
module bcd_tag_ram
  import bcd_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  tag_t             wdata,
  input  logic [IDX_W-1:0] raddr,
  output tag_t             rdata
);
  tag_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/block_cache_directory_unit.sv
// Top level of the block cache directory: sequencer, policy state and output register.
// Depends on bcd_pkg and bcd_tag_ram.
//
//   channel | valid     | ready     | payload
//   request | req_valid | req_ready | req (req_t)
//   result  | rsp_valid | rsp_ready | rsp (rsp_t)
//
// An access holds the unit for a tag scan with one registered tag read per
// cycle, a victim scan on an allocating miss and, on a hit or allocation, a
// minimum-age scan over the other valid entries and, when one of them has
// age zero, an aging pass. A flush walks all entries, one write-back result
// per dirty entry. Reset clears valid, dirty and age bits at once. A stalled
// result holds the walk; no new request is taken until the last result has left.
`timescale 1ns / 1ps
module block_cache_directory_unit
  import bcd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOOK   = 4'd1;
  localparam logic [3:0] S_VICT   = 4'd2;
  localparam logic [3:0] S_MIN    = 4'd3;
  localparam logic [3:0] S_AGE    = 4'd4;
  localparam logic [3:0] S_FLUSH  = 4'd5;
  localparam logic [3:0] S_FWB    = 4'd6;
  localparam logic [3:0] S_WAIT   = 4'd7;
  localparam logic [3:0] S_INST   = 4'd8;

  localparam rsp_t RSP_NONE = '{hit: 1'b0, entry_index: '0, allocated: 1'b0,
                                writeback_valid: 1'b0, wb_device: '0, wb_offset: '0,
                                wb_block: '0, wb_size: '0, last: 1'b1};

  logic [3:0]         state;
  req_t               cur;
  logic [IDX_W:0]     cnt;
  logic [IDX_W-1:0]   pos;
  logic [IDX_W-1:0]   raddr;
  logic [IDX_W-1:0]   tgt;
  logic [IDX_W-1:0]   victim;
  logic [AGE_W-1:0]   oldest;
  logic [AGE_W-1:0]   least;
  logic               found;
  logic               any_flush;
  logic               rd_pend;
  logic [ENTRIES-1:0] valid;
  logic [ENTRIES-1:0] dirty;
  logic [AGE_W-1:0]   age [ENTRIES];
  tag_t               rdata;
  tag_t               key;
  logic               we;
  logic               match;

  assign key   = '{device: cur.device_id, offset: cur.base_offset,
                   block: cur.block_number, size: cur.block_size};
  assign match = valid[pos] && (rdata == key);
  assign we    = (state == S_INST);
  assign req_ready = (state == S_IDLE) && !rsp_valid;
  assign raddr = cnt[IDX_W-1:0];

  bcd_tag_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (tgt),
    .wdata (key),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      dirty     <= '0;
      rsp_valid <= 1'b0;
      rd_pend   <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) age[i] <= '0;
    end else begin
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            cur <= req;
            cnt <= '0;
            found <= 1'b0;
            any_flush <= 1'b0;
            rd_pend <= 1'b0;
            if (req.opcode == OP_READ || req.opcode == OP_WRITE) begin
              state <= S_LOOK;
            end else if (req.opcode == OP_FLUSH) begin
              state <= S_FLUSH;
            end else begin
              rsp <= RSP_NONE;
              rsp_valid <= 1'b1;
            end
          end
        end
        S_LOOK: begin
          // cnt issues reads; pos is the entry whose tag is in rdata
          if (rd_pend && match) begin
            found <= 1'b1;
            tgt <= pos;
            if (cur.opcode == OP_WRITE) dirty[pos] <= 1'b1;
            cnt <= '0;
            least <= AGE_W'(AGE_LIMIT);
            rd_pend <= 1'b0;
            state <= S_MIN;
          end else if (rd_pend && pos == IDX_W'(ENTRIES - 1)) begin
            rd_pend <= 1'b0;
            if (!cur.allocate_on_miss) begin
              rsp <= RSP_NONE;
              rsp_valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              cnt <= '0;
              victim <= '0;
              oldest <= '0;
              state <= S_VICT;
            end
          end else if (cnt != (IDX_W+1)'(ENTRIES)) begin
            pos <= cnt[IDX_W-1:0];
            rd_pend <= 1'b1;
            cnt <= cnt + 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
        end
        S_VICT: begin
          if (cnt == (IDX_W+1)'(ENTRIES)) begin
            tgt <= victim;
            cnt <= {1'b0, victim};
            rd_pend <= 1'b0;
            state <= S_WAIT;
          end else if (!valid[cnt[IDX_W-1:0]]) begin
            victim <= cnt[IDX_W-1:0];
            tgt <= cnt[IDX_W-1:0];
            state <= S_WAIT;
            rd_pend <= 1'b0;
          end else begin
            if (age[cnt[IDX_W-1:0]] >= oldest) begin
              oldest <= age[cnt[IDX_W-1:0]];
              victim <= cnt[IDX_W-1:0];
            end
            cnt <= cnt + 1'b1;
          end
        end
        S_WAIT: begin
          // read victim tag for a possible write-back
          cnt <= {1'b0, tgt};
          if (rd_pend && !rsp_valid) begin
            rsp.hit <= 1'b0;
            rsp.entry_index <= 6'(tgt);
            rsp.allocated <= 1'b1;
            rsp.writeback_valid <= valid[tgt] && dirty[tgt];
            rsp.wb_device <= (valid[tgt] && dirty[tgt]) ? rdata.device : '0;
            rsp.wb_offset <= (valid[tgt] && dirty[tgt]) ? rdata.offset : '0;
            rsp.wb_block  <= (valid[tgt] && dirty[tgt]) ? rdata.block  : '0;
            rsp.wb_size   <= (valid[tgt] && dirty[tgt]) ? rdata.size   : '0;
            rsp.last <= 1'b1;
            rsp_valid <= 1'b1;
            state <= S_INST;
          end
          rd_pend <= (cnt[IDX_W-1:0] == tgt);
        end
        S_INST: begin
          valid[tgt] <= 1'b1;
          dirty[tgt] <= 1'b0;
          cnt <= '0;
          least <= AGE_W'(AGE_LIMIT);
          state <= S_MIN;
        end
        S_MIN: begin
          if (cnt == (IDX_W+1)'(ENTRIES)) begin
            age[tgt] <= '0;
            cnt <= '0;
            state <= S_AGE;
          end else begin
            if (cnt[IDX_W-1:0] != tgt && valid[cnt[IDX_W-1:0]] &&
                age[cnt[IDX_W-1:0]] < least) begin
              least <= age[cnt[IDX_W-1:0]];
            end
            cnt <= cnt + 1'b1;
          end
        end
        S_AGE: begin
          if (least != '0 || cnt == (IDX_W+1)'(ENTRIES)) begin
            if (found) begin
              rsp <= '{hit: 1'b1, entry_index: 6'(tgt), allocated: 1'b0,
                       writeback_valid: 1'b0, wb_device: '0, wb_offset: '0,
                       wb_block: '0, wb_size: '0, last: 1'b1};
              rsp_valid <= 1'b1;
            end
            state <= S_IDLE;
          end else begin
            if (cnt[IDX_W-1:0] != tgt && age[cnt[IDX_W-1:0]] < AGE_W'(AGE_LIMIT)) begin
              age[cnt[IDX_W-1:0]] <= age[cnt[IDX_W-1:0]] + 1'b1;
            end
            cnt <= cnt + 1'b1;
          end
        end
        S_FLUSH: begin
          // scan for the next dirty entry; cnt addresses the tag ram
          if (rsp_valid) begin
          end else if (cnt == (IDX_W+1)'(ENTRIES)) begin
            if (!any_flush) begin
              rsp <= RSP_NONE;
              rsp_valid <= 1'b1;
            end
            state <= S_IDLE;
          end else if (valid[cnt[IDX_W-1:0]] && dirty[cnt[IDX_W-1:0]]) begin
            pos <= cnt[IDX_W-1:0];
            state <= S_FWB;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FWB: begin
          if (!rsp_valid) begin
            logic more;
            more = 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
              if (i > int'(pos) && valid[i] && dirty[i]) more = 1'b1;
            end
            rsp.hit <= 1'b0;
            rsp.entry_index <= 6'(pos);
            rsp.allocated <= 1'b0;
            rsp.writeback_valid <= 1'b1;
            rsp.wb_device <= rdata.device;
            rsp.wb_offset <= rdata.offset;
            rsp.wb_block  <= rdata.block;
            rsp.wb_size   <= rdata.size;
            rsp.last <= !more;
            rsp_valid <= 1'b1;
            dirty[pos] <= 1'b0;
            any_flush <= 1'b1;
            cnt <= cnt + 1'b1;
            state <= S_FLUSH;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: design/bcd_checker.sv
// Port checker for block_cache_directory_unit, attached by bind.
// Depends on bcd_pkg.
`timescale 1ns / 1ps
module bcd_port_checks
  import bcd_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request dropped or changed while waiting");
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result dropped or changed while stalled");
  a_no_req_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("request taken while result pending");
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.hit |-> !rsp.allocated && !rsp.writeback_valid)
    else $error("hit with allocation or write-back");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken back to back");
endmodule

bind block_cache_directory_unit bcd_port_checks u_bcd_checker (.*);
